>>> design/ddo_pkg.sv
package ddo_pkg;

  // default number of rotation steps
  localparam int CordicStepsDefault = 16;

  // input queue depth between front and back
  localparam int FifoDepth = 2;

  // configuration register indexes
  localparam logic [1:0] RegMetersPerPulse  = 2'd0;
  localparam logic [1:0] RegRadiansPerPulse = 2'd1;
  localparam logic [1:0] RegInvWheelBase    = 2'd2;

  // reset value of the inverse wheel base, 1.0 in Q16.16
  localparam logic [31:0] InvWheelBaseReset = 32'h0001_0000;

  // 2^32 / (2 pi) in Q30.0, rounded
  localparam logic [29:0] RadToBam = 30'd683565276;

  // cordic start value, 0.6072529 in Q4.30
  localparam logic signed [33:0] CordicStart = 34'sd652032875;

  // microseconds per second
  localparam logic [19:0] UsPerS = 20'd1000000;

  // arctangent of 2^-i as a binary angle
  localparam logic [31:0] AtanBam [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // one queued update
  typedef struct packed {
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [31:0] elapsed_us;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [31:0] meters_per_pulse;
    logic [31:0] radians_per_pulse;
    logic [31:0] inverse_wheel_base;
  } cfg_t;

endpackage

>>> design/ddo_if.sv
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic        [31:0] elapsed_us;

  modport source (output valid, left_count, right_count, elapsed_us, input ready);
  modport sink (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic        [31:0] heading;
  logic signed [31:0] linear_speed;
  logic signed [31:0] angular_speed;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;
  logic signed [47:0] left_angle;
  logic signed [47:0] right_angle;

  modport source (
    output valid, pos_x, pos_y, heading, linear_speed, angular_speed,
           left_speed, right_speed, left_angle, right_angle,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, heading, linear_speed, angular_speed,
           left_speed, right_speed, left_angle, right_angle,
    output ready
  );
endinterface

>>> design/ddo_front.sv
module ddo_front (
  ddo_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output ddo_pkg::item_t  item_o
);

  // accept whenever the queue has room
  assign in_i.ready = !full_i;

  // zero elapsed time is dropped here and never reaches the back end
  assign push_o = in_i.valid && !full_i && (in_i.elapsed_us != 32'd0);

  assign item_o.left_count  = in_i.left_count;
  assign item_o.right_count = in_i.right_count;
  assign item_o.elapsed_us  = in_i.elapsed_us;

endmodule

>>> design/ddo_fifo.sv
module ddo_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ddo_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output ddo_pkg::item_t  item_o,
  output logic            empty_o
);

  localparam int PtrW = (ddo_pkg::FifoDepth > 1) ? $clog2(ddo_pkg::FifoDepth) : 1;
  localparam int CntW = $clog2(ddo_pkg::FifoDepth + 1);

  ddo_pkg::item_t mem_q [ddo_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(ddo_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ddo_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ddo_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> design/ddo_div.sv
module ddo_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [41:0] value_i,
  input  logic        [31:0] us_i,
  output logic               done_o,
  output logic signed [31:0] result_o
);

  typedef enum logic [2:0] {D_IDLE, D_MUL, D_CHK, D_RUN, D_FIN} div_state_e;

  div_state_e         state_q;
  logic               neg_q;
  logic        [40:0] mag_q;
  logic        [31:0] us_q;
  logic        [60:0] num_q;
  logic        [31:0] rem_q;
  logic        [31:0] quo_q;
  logic        [4:0]  cnt_q;
  logic signed [31:0] res_q;

  logic [41:0] mag_in;
  logic [32:0] trial;
  logic        ge;

  assign mag_in = value_i[41] ? 42'(-value_i) : 42'(value_i);
  assign trial  = {rem_q, quo_q[31]};
  assign ge     = (trial >= {1'b0, us_q});

  assign done_o   = (state_q == D_IDLE);
  assign result_o = res_q;

  // value * 1e6 / us, truncated toward zero and saturated, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q   <= value_i[41];
            mag_q   <= mag_in[40:0];
            us_q    <= us_i;
            state_q <= D_MUL;
          end
        end
        D_MUL: begin
          num_q   <= 61'(mag_q) * 61'(ddo_pkg::UsPerS);
          state_q <= D_CHK;
        end
        D_CHK: begin
          // quotient of 2^32 or more always saturates
          if ({3'b000, num_q[60:32]} >= us_q) begin
            res_q   <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            state_q <= D_IDLE;
          end else begin
            rem_q   <= {3'b000, num_q[60:32]};
            quo_q   <= num_q[31:0];
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= ge ? 32'(trial - {1'b0, us_q}) : trial[31:0];
          quo_q <= {quo_q[30:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          if (neg_q) begin
            res_q <= (quo_q > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-quo_q);
          end else begin
            res_q <= quo_q[31] ? 32'sh7FFF_FFFF : quo_q;
          end
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

>>> design/ddo_back.sv
module ddo_back #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ddo_pkg::cfg_t   cfg_i,
  input  logic            empty_i,
  input  ddo_pkg::item_t  item_i,
  output logic            pop_o,
  ddo_out_if.source       out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DELTA, S_DIST, S_HEAD, S_BAM, S_ANG, S_ROT, S_POS, S_ACC, S_OUT
  } seq_state_e;

  localparam logic signed [48:0] DthLim = 49'sd1099511627776;

  seq_state_e state_q;

  // update state
  logic        [31:0] prev_l_q, prev_r_q;
  logic        [47:0] acc_x_q, acc_y_q;
  logic        [31:0] acc_h_q;

  // per item work registers
  logic        [31:0] lc_q, rc_q, us_q;
  logic signed [64:0] prod_l_q, prod_r_q;
  logic signed [47:0] ang_l_q, ang_r_q;
  logic signed [31:0] dl_q, dr_q, mean_q;
  logic signed [65:0] prod_th_q;
  logic        [47:0] plo_q;
  logic        [15:0] phi_q;
  logic signed [41:0] dth_c_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic        [5:0]  step_q;
  logic signed [35:0] px_q, py_q;

  // result register
  logic               out_valid_q;
  logic signed [47:0] pos_x_q, pos_y_q;
  logic        [31:0] heading_q;
  logic signed [31:0] lin_q, angv_q, lsp_q, rsp_q;
  logic signed [47:0] lang_q, rang_q;

  // combinational datapath
  logic        [31:0] dl_raw, dr_raw;
  logic signed [64:0] mul_l, mul_r, mul_al, mul_ar;
  logic signed [32:0] wsum, wdiff;
  logic signed [65:0] mul_th;
  logic signed [48:0] dth;
  logic        [61:0] mul_lo;
  logic        [45:0] mul_hi;
  logic        [47:0] bam_sum;
  logic        [31:0] hd;
  logic               fold;
  logic        [31:0] ang_f;
  logic signed [33:0] xs, ys, atan_s, cs, sn;
  logic signed [65:0] mul_px, mul_py;
  logic               div_start;
  logic        [3:0]  div_done;
  logic signed [31:0] div_res [4];
  logic               out_free;
  logic               out_load;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if ((v[48:31] == '0) || (v[48:31] == '1)) begin
      return v[31:0];
    end
    return v[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // wheel deltas with 32-bit wrap scaled to distance, absolute counts scaled to wheel angle
  assign dl_raw = lc_q - prev_l_q;
  assign dr_raw = rc_q - prev_r_q;
  assign mul_l  = $signed(dl_raw) * $signed({1'b0, cfg_i.meters_per_pulse});
  assign mul_r  = $signed(dr_raw) * $signed({1'b0, cfg_i.meters_per_pulse});
  assign mul_al = $signed(lc_q) * $signed({1'b0, cfg_i.radians_per_pulse});
  assign mul_ar = $signed(rc_q) * $signed({1'b0, cfg_i.radians_per_pulse});

  // mean distance and heading change
  assign wsum   = 33'(dl_q) + 33'(dr_q);
  assign wdiff  = 33'(dr_q) - 33'(dl_q);
  assign mul_th = $signed(wdiff) * $signed({1'b0, cfg_i.inverse_wheel_base});
  assign dth    = prod_th_q[64:16];

  // radians to binary angle, low 48 bits of the product in two parts
  assign mul_lo  = dth[31:0] * ddo_pkg::RadToBam;
  assign mul_hi  = dth[47:32] * ddo_pkg::RadToBam;
  assign bam_sum = plo_q + {phi_q, 32'h0};
  assign hd      = acc_h_q + bam_sum[47:16];

  // fold the second and third quadrant by a half turn
  assign fold  = hd[31] ^ hd[30];
  assign ang_f = {hd[31] ^ fold, hd[30:0]};

  // rotation step
  assign xs     = x_q >>> step_q[4:0];
  assign ys     = y_q >>> step_q[4:0];
  assign atan_s = {2'b00, ddo_pkg::AtanBam[step_q[4:0]]};
  assign cs     = flip_q ? -x_q : x_q;
  assign sn     = flip_q ? -y_q : y_q;

  // position step
  assign mul_px = mean_q * cs;
  assign mul_py = mean_q * sn;

  assign div_start = (state_q == S_ANG);
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_load  = (state_q == S_OUT) && (div_done == 4'hF) && out_free;
  assign pop_o     = (state_q == S_IDLE) && !empty_i;

  // speed dividers, one lane per speed
  ddo_div u_div_lin (
    .clk_i, .rst_ni, .start_i(div_start), .value_i(42'(mean_q)), .us_i(us_q),
    .done_o(div_done[0]), .result_o(div_res[0])
  );
  ddo_div u_div_ang (
    .clk_i, .rst_ni, .start_i(div_start), .value_i(dth_c_q), .us_i(us_q),
    .done_o(div_done[1]), .result_o(div_res[1])
  );
  ddo_div u_div_left (
    .clk_i, .rst_ni, .start_i(div_start), .value_i(42'(dl_q)), .us_i(us_q),
    .done_o(div_done[2]), .result_o(div_res[2])
  );
  ddo_div u_div_right (
    .clk_i, .rst_ni, .start_i(div_start), .value_i(42'(dr_q)), .us_i(us_q),
    .done_o(div_done[3]), .result_o(div_res[3])
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_h_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            lc_q    <= item_i.left_count;
            rc_q    <= item_i.right_count;
            us_q    <= item_i.elapsed_us;
            state_q <= S_DELTA;
          end
        end
        S_DELTA: begin
          prod_l_q <= mul_l;
          prod_r_q <= mul_r;
          ang_l_q  <= mul_al[63:16];
          ang_r_q  <= mul_ar[63:16];
          prev_l_q <= lc_q;
          prev_r_q <= rc_q;
          state_q  <= S_DIST;
        end
        S_DIST: begin
          dl_q    <= sat32(prod_l_q[64:16]);
          dr_q    <= sat32(prod_r_q[64:16]);
          state_q <= S_HEAD;
        end
        S_HEAD: begin
          mean_q    <= wsum[32:1];
          prod_th_q <= mul_th;
          state_q   <= S_BAM;
        end
        S_BAM: begin
          plo_q <= mul_lo[47:0];
          phi_q <= mul_hi[15:0];
          if (dth > DthLim) begin
            dth_c_q <= 42'(DthLim);
          end else if (dth < -DthLim) begin
            dth_c_q <= 42'(-DthLim);
          end else begin
            dth_c_q <= 42'(dth);
          end
          state_q <= S_ANG;
        end
        S_ANG: begin
          acc_h_q <= hd;
          flip_q  <= fold;
          x_q     <= ddo_pkg::CordicStart;
          y_q     <= '0;
          z_q     <= 34'($signed(ang_f));
          step_q  <= '0;
          state_q <= S_ROT;
        end
        S_ROT: begin
          if (!z_q[33]) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_s;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_s;
          end
          step_q <= step_q + 1'b1;
          if (step_q == 6'(CORDIC_STEPS - 1)) begin
            state_q <= S_POS;
          end
        end
        S_POS: begin
          px_q    <= mul_px[65:30];
          py_q    <= mul_py[65:30];
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_x_q <= acc_x_q + 48'(px_q);
          acc_y_q <= acc_y_q + 48'(py_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            pos_x_q     <= acc_x_q;
            pos_y_q     <= acc_y_q;
            heading_q   <= acc_h_q;
            lin_q       <= div_res[0];
            angv_q      <= div_res[1];
            lsp_q       <= div_res[2];
            rsp_q       <= div_res[3];
            lang_q      <= ang_l_q;
            rang_q      <= ang_r_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pos_x         = pos_x_q;
  assign out_o.pos_y         = pos_y_q;
  assign out_o.heading       = heading_q;
  assign out_o.linear_speed  = lin_q;
  assign out_o.angular_speed = angv_q;
  assign out_o.left_speed    = lsp_q;
  assign out_o.right_speed   = rsp_q;
  assign out_o.left_angle    = lang_q;
  assign out_o.right_angle   = rang_q;

`ifndef NO_ASSERTIONS
  // rotation never runs past the configured step count
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROT |-> step_q < 6'(CORDIC_STEPS))
    else $error("rotation step counter out of range");

  // heading only moves in the angle update cycle
  a_heading_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_ANG |=> $stable(acc_h_q))
    else $error("heading changed outside the angle update");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_o.ready) |=> state_q == S_OUT)
    else $error("result register overwritten while stalled");

  // the speed dividers are idle when a new item starts
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_done == 4'hF)
    else $error("divider busy at start");
`endif

endmodule

>>> design/differential_drive_odometry.sv
// Differential-drive wheel odometry.
// Input channel in_i carries absolute left and right encoder counts and the
// microseconds since the previous update; a transaction with zero elapsed
// time is dropped and changes nothing. Output channel out_o carries one
// result per other transaction: pose (x, y in Q32.16 m, heading as a 32-bit
// binary angle), linear and angular speed, wheel speeds and wheel angles.
// The APB port writes meters_per_pulse (0x0), radians_per_pulse (0x4) and
// inverse_wheel_base (0x8); write only while the block is idle.
// A front stage filters transactions into a two-entry queue, so up to two
// updates are taken while the back end is busy. The back end handles one
// update at a time: setup steps for the wheel deltas, distances, heading
// change and binary angle, then four speed dividers that produce one
// quotient bit a cycle and run alongside the rotation of CORDIC_STEPS steps;
// the dividers set when the result is ready. When the receiver stalls, the
// result waits in the output register, the back end holds the next one
// finished, and input stalls once the queue fills.
// Reset clears the stored counts, the pose, and the registers to their
// defaults (inverse_wheel_base 1.0).
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddo_in_if.sink      in_i,
  ddo_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ddo_pkg::cfg_t  cfg_q;
  ddo_pkg::item_t push_item, pop_item;
  logic           push, full, pop, empty;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.meters_per_pulse   <= '0;
      cfg_q.radians_per_pulse  <= '0;
      cfg_q.inverse_wheel_base <= ddo_pkg::InvWheelBaseReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ddo_pkg::RegMetersPerPulse:  cfg_q.meters_per_pulse   <= pwdata;
        ddo_pkg::RegRadiansPerPulse: cfg_q.radians_per_pulse  <= pwdata;
        ddo_pkg::RegInvWheelBase:    cfg_q.inverse_wheel_base <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      ddo_pkg::RegMetersPerPulse:  prdata = cfg_q.meters_per_pulse;
      ddo_pkg::RegRadiansPerPulse: prdata = cfg_q.radians_per_pulse;
      ddo_pkg::RegInvWheelBase:    prdata = cfg_q.inverse_wheel_base;
      default:                     prdata = '0;
    endcase
  end

  ddo_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  ddo_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  ddo_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .item_i  (pop_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
